// ===== src/fftm_pkg.sv =====
package fftm_pkg;

    localparam int LOG2_POINTS_DEF = 7;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_W = 12;
    localparam int PAIR_W = 6;
    localparam int MAG_W = 19;
    localparam int TW_W = 18;
    localparam longint unsigned PI_Q30 = 64'd3373259425;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int unsigned MAG_MAX = 524287;

    // controller states
    typedef enum logic [7:0] {
        ST_FILL  = 8'b0000_0001,
        ST_REV   = 8'b0000_0010,
        ST_RD_A  = 8'b0000_0100,
        ST_RD_B  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_WR    = 8'b0010_0000,
        ST_MAG   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        load_sample;
        logic        rev_copy;
        logic        rd_a;
        logic        rd_b;
        logic        mul;
        logic        wr_bfly;
        logic        mag_start;
        logic        mag_sel_odd;
    } cmd_t;

    // status from datapath
    typedef struct packed {
        logic mag_done;
    } stat_t;

    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // shift and subtract quotient, used only while building the twiddle table
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo, rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2, term, sum;
        x2 = mul_q30(x, x);
        term = x;
        sum = x;
        for (int k = 1; k <= 6; k++)
        begin
            term = div_u64(mul_q30(term, x2), longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) sum = sum - term;
            else sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned cos_q30(longint unsigned x);
        longint unsigned x2, term, sum;
        x2 = mul_q30(x, x);
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int k = 1; k <= 6; k++)
        begin
            term = div_u64(mul_q30(term, x2), longint'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) sum = sum - term;
            else sum = sum + term;
        end
        return sum;
    endfunction

    function automatic int q30_to_q15(longint unsigned v);
        return int'((v + 64'd16384) >> 15);
    endfunction

    // twiddle for index p, returned as {cos, sin}, each TW_W bits signed
    function automatic logic [2*TW_W-1:0] twiddle(int p, int lg);
        int n, q, e, r, a, cv, sv, c, s, oc, os;
        longint unsigned x;
        n = 1 << lg;
        q = n >> 2;
        e = n >> 3;
        r = (p >= q) ? p - q : p;
        a = (r > e) ? q - r : r;
        x = (64'd2 * PI_Q30 * longint'(a) + longint'(n >> 1)) >> lg;
        cv = q30_to_q15(cos_q30(x));
        sv = q30_to_q15(sin_q30(x));
        if (r > e) begin
            c = sv;
            s = cv;
        end else begin
            c = cv;
            s = sv;
        end
        if (p >= q) begin
            oc = -s;
            os = c;
        end else begin
            oc = c;
            os = s;
        end
        return {TW_W'(oc), TW_W'(os)};
    endfunction

endpackage

// ===== src/fftm_ram.sv =====
module fftm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/fftm_sqrt.sv =====
module fftm_sqrt
    import fftm_pkg::*;
#(
    parameter int IN_W = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IN_W-1:0] value,
    output logic            done,
    output logic [MAG_W-1:0] root
);

    localparam int RW = IN_W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [IN_W-1:0] rem_reg, rem_next;
    logic [RW-1:0]   res_reg, res_next;
    logic [IN_W-1:0] val_reg, val_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [IN_W+1:0] trial;
    logic [IN_W+1:0] rem_sh;

    // one result bit per cycle, restoring square root
    always_comb
    begin
        rem_sh   = {rem_reg, val_reg[IN_W-1 -: 2]};
        trial    = {res_reg, 2'b01};
        rem_next = rem_reg;
        res_next = res_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            res_next  = '0;
            val_next  = value;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = val_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next = IN_W'(rem_sh - trial);
                res_next = {res_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next = IN_W'(rem_sh);
                res_next = {res_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        val_reg <= val_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign root = (res_next > RW'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(res_next);

endmodule

// ===== src/fftm_datapath.sv =====
module fftm_datapath
    import fftm_pkg::*;
#(
    parameter int LOG2_POINTS = LOG2_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DW = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic [LOG2_POINTS-1:0] addr_a,
    input  logic [LOG2_POINTS-1:0] addr_b,
    input  logic [LOG2_POINTS-2:0] tw_idx,
    output stat_t                  stat,
    output logic [MAG_W-1:0]       mag
);

    localparam int N = 1 << LOG2_POINTS;
    localparam int AW = LOG2_POINTS;
    localparam int PW = DW + TW_W;
    localparam int SQW = 2 * DW;
    localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [AW-1:0]  wa_re, ra_re, wa_im, ra_im;
    logic [DW-1:0]  wd_re, wd_im, rd_re, rd_im;
    logic           we_re, we_im;
    logic [AW-1:0]  stage_addr_reg;
    logic [AW-1:0]  prev_a_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PW:0]   wr_reg, wi_reg;
    logic signed [TW_W-1:0] tc, ts;
    logic [2*TW_W-1:0] tw_rom [N/2];
    logic signed [DW-1:0] wr_c, wi_c;
    logic           wr_hi_reg;
    logic           mul_d_reg;
    logic [AW-1:0]  rev_a;
    logic [DW-1:0]  abs_re, abs_im;
    logic [SQW:0]   sq_sum;
    logic [SQW:0]   sq_reg;
    logic           sq_go_reg;
    logic           rd_sel_reg;
    logic           mag_pend_reg;

    // twiddle table built at elaboration
    for (genvar p = 0; p < N / 2; p++)
    begin : g_tw
        assign tw_rom[p] = twiddle(p, LOG2_POINTS);
    end
    assign tc = tw_rom[tw_idx][2*TW_W-1:TW_W];
    assign ts = tw_rom[tw_idx][TW_W-1:0];

    // bit reverse of addr_a
    for (genvar b = 0; b < AW; b++)
    begin : g_rev
        assign rev_a[b] = addr_a[AW-1-b];
    end

    fftm_ram #(.WIDTH(DW), .DEPTH(N)) u_re (
        .clk(clk), .we(we_re), .waddr(wa_re), .wdata(wd_re), .raddr(ra_re), .rdata(rd_re)
    );
    fftm_ram #(.WIDTH(DW), .DEPTH(N)) u_im (
        .clk(clk), .we(we_im), .waddr(wa_im), .wdata(wd_im), .raddr(ra_im), .rdata(rd_im)
    );

    // rounded butterfly products
    assign wr_c = DW'((wr_reg + (PW+1)'(16384)) >>> 15);
    assign wi_c = DW'((wi_reg + (PW+1)'(16384)) >>> 15);

    // memory port steering
    always_comb
    begin
        we_re = 1'b0;
        we_im = 1'b0;
        wa_re = addr_a;
        wa_im = addr_a;
        wd_re = DW'(sample & SMASK);
        wd_im = '0;
        ra_re = addr_a;
        ra_im = addr_a;
        if (cmd.load_sample)
        begin
            // im store holds raw samples during fill
            we_im = 1'b1;
            wd_im = DW'(sample & SMASK);
        end
        else if (cmd.rev_copy)
        begin
            // read raw at addr_a, write it in the next cycle into re at bitrev
            // and clear the raw entry just read
            ra_im = addr_a;
            we_re = rd_sel_reg;
            wa_re = stage_addr_reg;
            wd_re = rd_im;
            we_im = rd_sel_reg;
            wa_im = prev_a_reg;
            wd_im = '0;
        end
        else if (cmd.rd_b)
        begin
            ra_re = addr_b;
            ra_im = addr_b;
        end
        else if (cmd.wr_bfly)
        begin
            we_re = 1'b1;
            we_im = 1'b1;
            wa_re = wr_hi_reg ? addr_b : addr_a;
            wa_im = wa_re;
            wd_re = wr_hi_reg ? DW'(ar_reg - wr_c) : DW'(ar_reg + wr_c);
            wd_im = wr_hi_reg ? DW'(ai_reg - wi_c) : DW'(ai_reg + wi_c);
        end
        else if (cmd.mag_start)
        begin
            ra_re = addr_a;
            ra_im = addr_a;
        end
    end

    // magnitude squared
    assign abs_re = rd_re[DW-1] ? DW'(-rd_re) : rd_re;
    assign abs_im = rd_im[DW-1] ? DW'(-rd_im) : rd_im;
    assign sq_sum = (SQW+1)'(abs_re * abs_re) + (SQW+1)'(abs_im * abs_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_sel_reg   <= 1'b0;
            wr_hi_reg    <= 1'b0;
            mul_d_reg    <= 1'b0;
            sq_go_reg    <= 1'b0;
            mag_pend_reg <= 1'b0;
        end
        else
        begin
            rd_sel_reg   <= cmd.rev_copy;
            wr_hi_reg    <= cmd.wr_bfly && !wr_hi_reg;
            mul_d_reg    <= cmd.mul;
            mag_pend_reg <= cmd.mag_start;
            sq_go_reg    <= mag_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_addr_reg <= rev_a;
        prev_a_reg     <= addr_a;
        if (cmd.rd_b)
        begin
            ar_reg <= rd_re;
            ai_reg <= rd_im;
        end
        if (cmd.mul)
        begin
            br_reg <= rd_re;
            bi_reg <= rd_im;
        end
        if (mul_d_reg)
        begin
            wr_reg <= (PW+1)'(br_reg * tc) + (PW+1)'(bi_reg * ts);
            wi_reg <= (PW+1)'(bi_reg * tc) - (PW+1)'(br_reg * ts);
        end
        if (mag_pend_reg)
        begin
            sq_reg <= sq_sum;
        end
    end

    fftm_sqrt #(.IN_W(SQW + 2)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_go_reg),
        .value((SQW+2)'(sq_reg)), .done(stat.mag_done), .root(mag)
    );

endmodule

// ===== src/fftm_ctrl.sv =====
module fftm_ctrl
    import fftm_pkg::*;
#(
    parameter int LOG2_POINTS = LOG2_POINTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic                   out_fire,
    input  stat_t                  stat,
    output cmd_t                   cmd,
    output logic [LOG2_POINTS-1:0] addr_a,
    output logic [LOG2_POINTS-1:0] addr_b,
    output logic [LOG2_POINTS-2:0] tw_idx,
    output logic                   in_ready,
    output logic                   out_load,
    output logic                   out_valid_set
);

    localparam int AW = LOG2_POINTS;
    localparam int SW = $clog2(LOG2_POINTS + 1);

    state_t         state_reg, state_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic [AW-2:0]  bf_reg, bf_next;
    logic [SW-1:0]  stg_reg, stg_next;
    logic           odd_reg, odd_next;
    logic           wsec_reg, wsec_next;
    logic [AW-1:0]  span;
    logic [AW-1:0]  j_lo, hi_part, k_idx;
    logic [AW-1:0]  lowmask;

    // butterfly index -> addresses: k = (bf high bits << stg+1) | (bf low bits)
    assign span    = AW'(1) << stg_reg;
    assign lowmask = span - AW'(1);
    assign j_lo    = AW'(bf_reg) & lowmask;
    assign hi_part = (AW'(bf_reg) & ~lowmask) << 1;
    assign k_idx   = hi_part | j_lo;
    assign tw_idx  = (AW-1)'(j_lo << (AW - 1 - stg_reg));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bf_next    = bf_reg;
        stg_next   = stg_reg;
        odd_next   = odd_reg;
        wsec_next  = wsec_reg;
        cmd        = '0;
        addr_a     = cnt_reg;
        addr_b     = k_idx | span;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        out_valid_set = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                in_ready = 1'b1;
                cmd.load_sample = in_fire;
                if (in_fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '1)
                    begin
                        state_next = ST_REV;
                        odd_next   = 1'b0;
                    end
                end
            end
            ST_REV:
            begin
                // odd_reg marks the trailing write cycle
                cmd.rev_copy = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (odd_reg)
                begin
                    state_next = ST_RD_A;
                    cnt_next   = '0;
                    bf_next    = '0;
                    stg_next   = '0;
                    odd_next   = 1'b0;
                end
                else if (cnt_reg == '1)
                begin
                    odd_next = 1'b1;
                end
            end
            ST_RD_A:
            begin
                cmd.rd_a = 1'b1;
                addr_a = k_idx;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_b = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                wsec_next = 1'b0;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                // first cycle registers products, low then high half written
                addr_a = k_idx;
                if (!wsec_reg)
                begin
                    wsec_next = 1'b1;
                end
                else if (odd_reg)
                begin
                    cmd.wr_bfly = 1'b1;
                    wsec_next = 1'b0;
                    odd_next = 1'b0;
                    bf_next = bf_reg + 1'b1;
                    state_next = ST_RD_A;
                    if (bf_reg == '1)
                    begin
                        stg_next = stg_reg + 1'b1;
                        if (stg_reg == SW'(LOG2_POINTS - 1))
                        begin
                            state_next = ST_MAG;
                            cnt_next = '0;
                        end
                    end
                end
                else
                begin
                    cmd.wr_bfly = 1'b1;
                    odd_next = 1'b1;
                end
            end
            ST_MAG:
            begin
                cmd.mag_start = 1'b1;
                state_next = ST_OUT;
                odd_next = 1'b0;
            end
            ST_OUT:
            begin
                addr_a = cnt_reg;
                if (stat.mag_done)
                begin
                    if (!cnt_reg[0])
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ST_MAG;
                        out_load = 1'b1;
                    end
                    else
                    begin
                        cmd.mag_sel_odd = 1'b1;
                        out_valid_set = 1'b1;
                        odd_next = 1'b1;
                    end
                end
                else if (odd_reg && out_fire)
                begin
                    odd_next = 1'b0;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = (cnt_reg == '1) ? ST_FILL : ST_MAG;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            cnt_reg   <= '0;
            bf_reg    <= '0;
            stg_reg   <= '0;
            odd_reg   <= 1'b0;
            wsec_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bf_reg    <= bf_next;
            stg_reg   <= stg_next;
            odd_reg   <= odd_next;
            wsec_reg  <= wsec_next;
        end
    end

endmodule

// ===== src/fft_magnitude_spectrum_unit.sv =====
// after a frame's last sample: a bit-reversed copy pass, then 7 * N/2 butterflies,
// then the magnitudes of two bins per result
// throughput: one sample per cycle while filling, 64 results per frame; no samples are
// taken from a frame's end until its last result is taken
// results are computed one bin at a time by a bit-serial square root
// reset: rst_n asynchronous active low, returns to filling with an empty frame
module fft_magnitude_spectrum_unit
    import fftm_pkg::*;
#(
    parameter int LOG2_POINTS = LOG2_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                ready_in,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                valid_out,
    input  logic                ready_out,
    output logic [PAIR_W-1:0]   bin_pair,
    output logic [MAG_W-1:0]    mag_even,
    output logic [MAG_W-1:0]    mag_odd,
    output logic                last
);

    localparam int AW = LOG2_POINTS;

    cmd_t           cmd;
    stat_t          stat;
    logic [AW-1:0]  addr_a, addr_b;
    logic [AW-2:0]  tw_idx;
    logic [MAG_W-1:0] mag;
    logic           out_load, out_valid_set;
    logic           valid_reg;
    logic [MAG_W-1:0] even_reg, odd_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic           last_reg;

    fftm_ctrl #(.LOG2_POINTS(LOG2_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(valid_in && ready_in),
        .out_fire(valid_out && ready_out), .stat(stat), .cmd(cmd),
        .addr_a(addr_a), .addr_b(addr_b), .tw_idx(tw_idx), .in_ready(ready_in),
        .out_load(out_load), .out_valid_set(out_valid_set)
    );

    fftm_datapath #(.LOG2_POINTS(LOG2_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(sample), .addr_a(addr_a),
        .addr_b(addr_b), .tw_idx(tw_idx), .stat(stat), .mag(mag)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_valid_set)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready_out)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            even_reg <= mag;
        end
        if (cmd.mag_sel_odd)
        begin
            odd_reg  <= mag;
            pair_reg <= PAIR_W'(addr_a >> 1);
            last_reg <= (addr_a == '1);
        end
    end

    assign valid_out = valid_reg;
    assign bin_pair  = pair_reg;
    assign mag_even  = even_reg;
    assign mag_odd   = odd_reg;
    assign last      = last_reg;

endmodule

// ===== src/fftm_checker.sv =====
module fftm_checker
    import fftm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              valid_in,
    input logic              ready_in,
    input logic              valid_out,
    input logic              ready_out,
    input logic [PAIR_W-1:0] bin_pair,
    input logic              last
);

    // no samples taken while a result is shown
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> !ready_in) else $error("input open during output");

    // last only on the top pair
    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && last) |-> (bin_pair == '1)) else $error("last on wrong pair");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && !ready_out) |=> (valid_out && $stable(bin_pair)))
        else $error("result dropped");

endmodule

bind fft_magnitude_spectrum_unit fftm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .ready_in(ready_in),
    .valid_out(valid_out), .ready_out(ready_out), .bin_pair(bin_pair), .last(last)
);

// ===== sim/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fftm_pkg::*;

    localparam int NPTS = 128;
    localparam int NHALF = NPTS / 2;
    localparam int FRAMES = 1;

    typedef struct {
        logic [PAIR_W-1:0] pair;
        logic [MAG_W-1:0]  even;
        logic [MAG_W-1:0]  odd;
        logic              lst;
    } spec_t;

    logic                clk;
    logic                rst_n;
    logic                valid_in;
    logic                ready_in;
    logic [SAMPLE_W-1:0] sample;
    logic                valid_out;
    logic                ready_out;
    logic [PAIR_W-1:0]   bin_pair;
    logic [MAG_W-1:0]    mag_even;
    logic [MAG_W-1:0]    mag_odd;
    logic                last;

    logic [SAMPLE_W-1:0] pending_samples[$];
    spec_t               expected_bins[$];
    longint              frame_re[NPTS];
    longint              frame_im[NPTS];
    longint              cos_tab[NHALF];
    longint              sin_tab[NHALF];
    int                  fill_idx;
    int                  in_gap;
    int                  out_gap;
    int                  mismatches;
    int                  bins_checked;
    int                  frames_done;
    bit                  stim_done;

    fft_magnitude_spectrum_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_in),
        .ready_in  (ready_in),
        .sample    (sample),
        .valid_out (valid_out),
        .ready_out (ready_out),
        .bin_pair  (bin_pair),
        .mag_even  (mag_even),
        .mag_odd   (mag_odd),
        .last      (last)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // series in 30 fraction bits, unsigned wrap like 64-bit hardware
    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned series30(longint unsigned x, bit is_sin);
        longint unsigned x2, term, acc;
        longint unsigned dv;
        x2 = fx_mul(x, x);
        term = is_sin ? x : (64'd1 << 30);
        acc = term;
        for (int k = 1; k <= 6; k++)
        begin
            dv = is_sin ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
            term = fx_mul(term, x2) / dv;
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        return acc;
    endfunction

    // fill twiddle tables for all p in [0, N/2)
    task automatic make_twiddles();
        longint unsigned x;
        longint cq, sq, c, s;
        int r, a;
        for (int p = 0; p < NHALF; p++)
        begin
            r = (p >= NPTS / 4) ? p - NPTS / 4 : p;
            a = (r > NPTS / 8) ? NPTS / 4 - r : r;
            x = (64'd2 * PI_Q30 * longint'(a) + longint'(NPTS / 2)) >> 7;
            cq = longint'((series30(x, 1'b0) + 64'd16384) >> 15);
            sq = longint'((series30(x, 1'b1) + 64'd16384) >> 15);
            if (r > NPTS / 8)
            begin
                c = sq;
                s = cq;
            end
            else
            begin
                c = cq;
                s = sq;
            end
            if (p >= NPTS / 4)
            begin
                cos_tab[p] = -s;
                sin_tab[p] = c;
            end
            else
            begin
                cos_tab[p] = c;
                sin_tab[p] = s;
            end
        end
    endtask

    function automatic longint half_up15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic logic [MAG_W-1:0] bin_mag(longint re, longint im);
        longint unsigned v, res, bt;
        v = longint'(re * re + im * im);
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else res >>= 1;
            bt >>= 2;
        end
        return (res > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(res);
    endfunction

    // take one accepted sample; at frame end, transform and queue the spectrum
    task automatic spectrum_accept(logic [SAMPLE_W-1:0] s_in);
        longint tr[NPTS];
        longint ar, ai, br, bi, wr, wi, c, s;
        int rv, span, p;
        spec_t e;
        frame_re[fill_idx] = longint'(s_in);
        fill_idx = (fill_idx + 1) % NPTS;
        if (fill_idx != 0) return;
        for (int i = 0; i < NPTS; i++)
        begin
            rv = 0;
            for (int b = 0; b < 7; b++) if (i[b]) rv |= 1 << (6 - b);
            tr[rv] = frame_re[i];
        end
        for (int i = 0; i < NPTS; i++)
        begin
            frame_re[i] = tr[i];
            frame_im[i] = 0;
        end
        for (int st = 0; st < 7; st++)
        begin
            span = 1 << st;
            for (int j = 0; j < span; j++)
            begin
                p = j << (6 - st);
                c = cos_tab[p];
                s = sin_tab[p];
                for (int k = j; k < NPTS; k += 2 * span)
                begin
                    ar = frame_re[k];
                    ai = frame_im[k];
                    br = frame_re[k + span];
                    bi = frame_im[k + span];
                    wr = half_up15(br * c + bi * s);
                    wi = half_up15(bi * c - br * s);
                    frame_re[k] = ar + wr;
                    frame_im[k] = ai + wi;
                    frame_re[k + span] = ar - wr;
                    frame_im[k + span] = ai - wi;
                end
            end
        end
        for (int i = 0; i < NHALF; i++)
        begin
            e.pair = PAIR_W'(i);
            e.even = bin_mag(frame_re[2 * i], frame_im[2 * i]);
            e.odd = bin_mag(frame_re[2 * i + 1], frame_im[2 * i + 1]);
            e.lst = (i == NHALF - 1);
            expected_bins.push_back(e);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // stimulus: a directed frame then random frames
    initial
    begin
        make_twiddles();
        // alternating extremes with a single zero, exercises nyquist and every bit
        for (int i = 0; i < NPTS; i++)
            pending_samples.push_back((i == 5) ? 12'h000 : ((i % 2) ? 12'hFFF : 12'h000));
        // frames after it cycle through pure noise, sparse impulses, slow ramp (only noise with FRAMES = 1)
        for (int f = 0; f < FRAMES; f++)
            for (int i = 0; i < NPTS; i++)
                case (f % 3)
                    0: pending_samples.push_back(SAMPLE_W'($urandom));
                    1: pending_samples.push_back(($urandom_range(0, 7) == 0) ?
                                                 SAMPLE_W'($urandom) : '0);
                    default: pending_samples.push_back(SAMPLE_W'(i * 32));
                endcase
        // partial frame left unfinished, gives no spectrum
        for (int i = 0; i < 9; i++) pending_samples.push_back(SAMPLE_W'($urandom));
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in <= 1'b0;
            sample <= '0;
            in_gap <= 0;
            fill_idx = 0;
            stim_done <= 1'b0;
        end
        else
        begin
            if (valid_in && ready_in)
            begin
                spectrum_accept(sample);
            end
            if (valid_in && !ready_in)
            begin
                // hold item
            end
            else if (in_gap > 0)
            begin
                valid_in <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                valid_in <= 1'b1;
                sample <= pending_samples.pop_front();
                in_gap <= pick_gap();
            end
            else
            begin
                valid_in <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        spec_t e;
        if (!rst_n)
        begin
            ready_out <= 1'b0;
            out_gap <= 0;
            mismatches = 0;
            bins_checked = 0;
            frames_done = 0;
        end
        else
        begin
            if (valid_out && ready_out)
            begin
                if (expected_bins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction pair=%0d", bin_pair);
                end
                else
                begin
                    e = expected_bins.pop_front();
                    bins_checked++;
                    if (last) frames_done++;
                    if (bin_pair !== e.pair || mag_even !== e.even || mag_odd !== e.odd
                        || last !== e.lst)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp pair=%0d even=%0d odd=%0d last=%0b,",
                                      " got %0d %0d %0d %0b"},
                                     e.pair, e.even, e.odd, e.lst,
                                     bin_pair, mag_even, mag_odd, last);
                    end
                end
            end
            if (out_gap > 0)
            begin
                ready_out <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                ready_out <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        wait (stim_done && expected_bins.size() == 0);
        repeat (3000) @(posedge clk);
        $display("checked %0d bin-pair results over %0d complete frames", bins_checked, frames_done);
        $display("last frame left partial, no spectrum expected from it");
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
